### rtl/bgr_pkg.sv
`default_nettype none

package bgr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 24;
    localparam int NUM_ENT        = 9;
    localparam logic [3:0] LAST_IDX = 4'd8;

    typedef enum logic [2:0] {
        SEL_P0,
        SEL_P1,
        SEL_P2,
        SEL_CA,
        SEL_CB,
        SEL_DET
    } t_sel;

    typedef enum logic [1:0] {
        AOP_NONE,
        AOP_LOAD,
        AOP_ADD,
        AOP_SUB
    } t_aop;

    typedef enum logic [1:0] {
        OM_PROD,
        OM_PASS,
        OM_SING
    } t_omode;

    typedef struct packed {
        t_sel       sel;
        t_aop       aop;
        logic       load_in;
        logic       inv_ident;
        logic       cof_wr;
        logic       det_wr;
        logic       div_start;
        logic [3:0] div_idx;
        logic       out_load;
        t_omode     omode;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic div_done;
        logic out_busy;
    } t_sts;

    // cofactor k = +/- (g[A]*g[B] - g[C]*g[D])
    localparam logic [3:0] COF_A [NUM_ENT] = '{4'd4, 4'd3, 4'd3, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0};
    localparam logic [3:0] COF_B [NUM_ENT] = '{4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd5, 4'd5, 4'd4};
    localparam logic [3:0] COF_C [NUM_ENT] = '{4'd5, 4'd5, 4'd4, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1};
    localparam logic [3:0] COF_D [NUM_ENT] = '{4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd4, 4'd3, 4'd3};
    localparam logic       COF_NEG [NUM_ENT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    // inverse entry i takes the transposed cofactor
    localparam logic [3:0] TRANS [NUM_ENT] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

endpackage

`default_nettype wire

### rtl/bgr_div.sv
`default_nettype none

module bgr_div #(
    parameter int DATA_WIDTH = bgr_pkg::DATA_WIDTH_DEF,
    parameter int DET_W      = 2 * DATA_WIDTH - bgr_pkg::FRAC_BITS + 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DATA_WIDTH-1:0] i_num,
    input  wire logic signed [DET_W-1:0]      i_den,
    output logic                              o_done,
    output logic signed [DATA_WIDTH-1:0]      o_quot
);

    localparam int F   = bgr_pkg::FRAC_BITS;
    localparam int DW  = DATA_WIDTH;
    localparam int NW  = ((DW + F > DET_W) ? DW + F : DET_W) + 1;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);
    localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] WMIN = ~WMAX;
    localparam logic [NW-1:0] NMAX = NW'(WMAX);
    localparam logic [NW-1:0] NMIN_MAG = NMAX + NW'(1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DET_W-1:0]  r_rem;
    logic [DET_W-1:0]  r_ad;
    logic [NW-1:0]     r_num;
    logic              r_neg;

    logic [DW-1:0]     abs_n;
    logic [DET_W-1:0]  abs_d;
    logic [DET_W:0]    trial;
    logic              ge;
    logic [DET_W:0]    diff;
    logic [NW-1:0]     neg_q;

    always_comb begin
        abs_n = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
        abs_d = i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
        trial = {r_rem, r_num[NW-1]};
        ge    = trial >= {1'b0, r_ad};
        diff  = trial - {1'b0, r_ad};
        neg_q = -r_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_ad  <= abs_d;
            r_neg <= i_num[DW-1] != i_den[DET_W-1];
            r_num <= (NW'(abs_n) << F) + NW'(abs_d >> 1);
        end else if (r_busy) begin
            r_rem <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_num > NMIN_MAG) ? WMIN : neg_q[DW-1:0];
        end else begin
            o_quot = (r_num > NMAX) ? WMAX : r_num[DW-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

### rtl/bgr_dpath.sv
`default_nettype none

module bgr_dpath #(
    parameter int DATA_WIDTH = bgr_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bgr_pkg::t_cmd                i_cmd,
    output bgr_pkg::t_sts                     o_sts,
    input  wire logic signed [DATA_WIDTH-1:0] i_g [bgr_pkg::NUM_ENT],
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic signed [DATA_WIDTH-1:0]      o_r [bgr_pkg::NUM_ENT],
    output logic                              o_status
);

    localparam int F    = bgr_pkg::FRAC_BITS;
    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DW;
    localparam int AW   = 2 * DW + 3;
    localparam int DETW = 2 * DW - F + 3;
    localparam int N    = bgr_pkg::NUM_ENT;
    localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] WMIN = ~WMAX;
    localparam logic signed [AW-1:0] A_MAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [AW-1:0] A_MIN = ~A_MAX;
    localparam logic signed [AW-1:0] HALF = AW'(1) << (F - 1);
    localparam logic signed [DW-1:0] ONE = DW'(65'(1) << F);

    function automatic logic signed [DW-1:0] f_sat(input logic signed [AW-1:0] v);
        return (v > A_MAX) ? WMAX : ((v < A_MIN) ? WMIN : v[DW-1:0]);
    endfunction

    logic signed [DW-1:0]   r_g   [N];
    logic signed [DW-1:0]   r_inv [N];
    logic signed [DW-1:0]   r_cof [N];
    logic signed [DETW-1:0] r_det;
    bgr_pkg::t_aop          r_aop;
    logic                   r_ovalid;
    logic signed [DW-1:0]   r_r [N];
    logic                   r_status;

    logic signed [AW-1:0]   rnd_p [N];
    logic signed [DW-1:0]   cof_v [N];
    logic signed [DW-1:0]   prd_v [N];
    logic signed [AW-1:0]   det_sum;
    logic                   div_done;
    logic signed [DW-1:0]   div_q;

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int L = 3 * i + j;
            logic signed [DW-1:0] x;
            logic signed [DW-1:0] y;
            logic signed [PW-1:0] r_prod;
            logic signed [AW-1:0] r_acc;
            logic signed [AW-1:0] pext;
            logic signed [AW-1:0] rnd_n;

            always_comb begin
                case (i_cmd.sel)
                    bgr_pkg::SEL_P0: begin
                        x = r_g[3*i];
                        y = r_inv[j];
                    end
                    bgr_pkg::SEL_P1: begin
                        x = r_g[3*i+1];
                        y = r_inv[3+j];
                    end
                    bgr_pkg::SEL_P2: begin
                        x = r_g[3*i+2];
                        y = r_inv[6+j];
                    end
                    bgr_pkg::SEL_CA: begin
                        x = r_g[bgr_pkg::COF_A[L]];
                        y = r_g[bgr_pkg::COF_B[L]];
                    end
                    bgr_pkg::SEL_CB: begin
                        x = r_g[bgr_pkg::COF_C[L]];
                        y = r_g[bgr_pkg::COF_D[L]];
                    end
                    bgr_pkg::SEL_DET: begin
                        x = (L < 3) ? r_g[L] : '0;
                        y = r_cof[L];
                    end
                    default: begin
                        x = '0;
                        y = '0;
                    end
                endcase
            end

            always_ff @(posedge i_clk) begin
                r_prod <= PW'(x) * PW'(y);
            end

            assign pext = {{(AW-PW){r_prod[PW-1]}}, r_prod};

            always_ff @(posedge i_clk) begin
                case (r_aop)
                    bgr_pkg::AOP_LOAD: r_acc <= pext;
                    bgr_pkg::AOP_ADD:  r_acc <= r_acc + pext;
                    bgr_pkg::AOP_SUB:  r_acc <= r_acc - pext;
                    default:           r_acc <= r_acc;
                endcase
            end

            assign rnd_p[L] = (r_acc + HALF) >>> F;
            assign rnd_n    = (HALF - r_acc) >>> F;
            assign cof_v[L] = f_sat(bgr_pkg::COF_NEG[L] ? rnd_n : rnd_p[L]);
            assign prd_v[L] = f_sat(rnd_p[L]);
        end
    end

    assign det_sum = rnd_p[0] + rnd_p[1] + rnd_p[2];

    bgr_div #(
        .DATA_WIDTH(DW),
        .DET_W     (DETW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_cof[bgr_pkg::TRANS[i_cmd.div_idx]]),
        .i_den  (r_det),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aop <= bgr_pkg::AOP_NONE;
        end else begin
            r_aop <= i_cmd.aop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_g <= i_g;
        end
        if (i_cmd.cof_wr) begin
            r_cof <= cof_v;
        end
        if (i_cmd.det_wr) begin
            r_det <= det_sum[DETW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.inv_ident) begin
            for (int k = 0; k < N; k++) begin
                r_inv[k] <= (k == 0 || k == 4 || k == 8) ? ONE : '0;
            end
        end else if (div_done) begin
            r_inv[i_cmd.div_idx] <= div_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.omode)
                bgr_pkg::OM_PASS: begin
                    r_r      <= r_g;
                    r_status <= 1'b0;
                end
                bgr_pkg::OM_SING: begin
                    for (int k = 0; k < N; k++) begin
                        r_r[k] <= '0;
                    end
                    r_status <= 1'b1;
                end
                default: begin
                    r_r      <= prd_v;
                    r_status <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts    = '{det_zero: (r_det == '0), div_done: div_done,
                        out_busy: (r_ovalid && i_stall)};
    assign o_valid  = r_ovalid;
    assign o_r      = r_r;
    assign o_status = r_status;

endmodule

`default_nettype wire

### rtl/bgr_ctrl.sv
`default_nettype none

module bgr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_op,
    output logic               o_stall,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_data,
    output bgr_pkg::t_cmd      o_cmd,
    input  wire bgr_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PR0,
        ST_PR1,
        ST_PR2,
        ST_PRW,
        ST_CA,
        ST_CB,
        ST_CW,
        ST_CFIN,
        ST_DM,
        ST_DW,
        ST_DWR,
        ST_DCHK,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } t_state;

    t_state           r_state, n_state;
    logic             r_captured, n_captured;
    logic             r_pass;
    logic [3:0]       r_idx, n_idx;
    bgr_pkg::t_omode  r_omode, n_omode;
    logic             in_acc;

    assign in_acc  = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_captured = r_captured;
        n_idx      = r_idx;
        n_omode    = r_omode;
        o_cmd           = '0;
        o_cmd.sel       = bgr_pkg::SEL_P0;
        o_cmd.aop       = bgr_pkg::AOP_NONE;
        o_cmd.omode     = r_omode;
        o_cmd.div_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.load_in = 1'b1;
                    if (i_op) begin
                        o_cmd.inv_ident = 1'b1;
                        n_captured      = 1'b0;
                    end else if (r_pass) begin
                        n_omode = bgr_pkg::OM_PASS;
                        n_state = ST_OUT;
                    end else if (r_captured) begin
                        n_state = ST_PR0;
                    end else begin
                        n_state = ST_CA;
                    end
                end
            end
            ST_PR0: begin
                o_cmd.sel = bgr_pkg::SEL_P0;
                o_cmd.aop = bgr_pkg::AOP_LOAD;
                n_state   = ST_PR1;
            end
            ST_PR1: begin
                o_cmd.sel = bgr_pkg::SEL_P1;
                o_cmd.aop = bgr_pkg::AOP_ADD;
                n_state   = ST_PR2;
            end
            ST_PR2: begin
                o_cmd.sel = bgr_pkg::SEL_P2;
                o_cmd.aop = bgr_pkg::AOP_ADD;
                n_state   = ST_PRW;
            end
            ST_PRW: begin
                n_omode = bgr_pkg::OM_PROD;
                n_state = ST_OUT;
            end
            ST_CA: begin
                o_cmd.sel = bgr_pkg::SEL_CA;
                o_cmd.aop = bgr_pkg::AOP_LOAD;
                n_state   = ST_CB;
            end
            ST_CB: begin
                o_cmd.sel = bgr_pkg::SEL_CB;
                o_cmd.aop = bgr_pkg::AOP_SUB;
                n_state   = ST_CW;
            end
            ST_CW: begin
                n_state = ST_CFIN;
            end
            ST_CFIN: begin
                o_cmd.cof_wr = 1'b1;
                n_state      = ST_DM;
            end
            ST_DM: begin
                o_cmd.sel = bgr_pkg::SEL_DET;
                o_cmd.aop = bgr_pkg::AOP_LOAD;
                n_state   = ST_DW;
            end
            ST_DW: begin
                n_state = ST_DWR;
            end
            ST_DWR: begin
                o_cmd.det_wr = 1'b1;
                n_state      = ST_DCHK;
            end
            ST_DCHK: begin
                if (i_sts.det_zero) begin
                    n_omode = bgr_pkg::OM_SING;
                    n_state = ST_OUT;
                end else begin
                    n_idx   = '0;
                    n_state = ST_DSTART;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_sts.div_done) begin
                    if (r_idx == bgr_pkg::LAST_IDX) begin
                        n_captured = 1'b1;
                        n_state    = ST_PR0;
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_state = ST_DSTART;
                    end
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_captured <= 1'b0;
            r_pass     <= 1'b0;
            r_idx      <= '0;
            r_omode    <= bgr_pkg::OM_PROD;
        end else begin
            r_state    <= n_state;
            r_captured <= n_captured;
            r_idx      <= n_idx;
            r_omode    <= n_omode;
            if (i_cfg_valid) begin
                r_pass <= i_cfg_data;
            end
        end
    end

    a_capture_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_captured) |-> $past(r_state) == ST_DWAIT)
        else $error("capture armed outside the inverse phase");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result register loaded while held");

    a_singular_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DCHK && i_sts.det_zero) |=> (r_state == ST_OUT && !r_captured))
        else $error("singular birth gradient armed capture");

endmodule

`default_nettype wire

### rtl/birth_gradient_rereference_3x3.sv
// Re-references each 3x3 deformation gradient (Q8.24, row-major) to a stored birth
// gradient: R = F * inv(Fbirth), saturated to Q8.24. The first trial item after reset
// or a restart item (op = 1) becomes the birth gradient; a singular one returns zeros
// with status 1 and leaves capture pending. A trial item runs three accumulate steps on
// nine lane multipliers through a two-stage multiply-accumulate pipeline into the result
// register, and o_stall holds off the next item until it is done. The capturing item
// first adds cofactor and determinant work and nine serial restoring divisions, which a
// singular one skips. Restart items give no result. A result held by i_stall holds the
// next item in its output step. The config register is always ready.
`default_nettype none

module birth_gradient_rereference_3x3 #(
    parameter int DATA_WIDTH = bgr_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_op,
    input  wire logic signed [DATA_WIDTH-1:0] i_g11,
    input  wire logic signed [DATA_WIDTH-1:0] i_g12,
    input  wire logic signed [DATA_WIDTH-1:0] i_g13,
    input  wire logic signed [DATA_WIDTH-1:0] i_g21,
    input  wire logic signed [DATA_WIDTH-1:0] i_g22,
    input  wire logic signed [DATA_WIDTH-1:0] i_g23,
    input  wire logic signed [DATA_WIDTH-1:0] i_g31,
    input  wire logic signed [DATA_WIDTH-1:0] i_g32,
    input  wire logic signed [DATA_WIDTH-1:0] i_g33,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_r11,
    output logic signed [DATA_WIDTH-1:0]      o_r12,
    output logic signed [DATA_WIDTH-1:0]      o_r13,
    output logic signed [DATA_WIDTH-1:0]      o_r21,
    output logic signed [DATA_WIDTH-1:0]      o_r22,
    output logic signed [DATA_WIDTH-1:0]      o_r23,
    output logic signed [DATA_WIDTH-1:0]      o_r31,
    output logic signed [DATA_WIDTH-1:0]      o_r32,
    output logic signed [DATA_WIDTH-1:0]      o_r33,
    output logic                              o_status,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_data
);

    bgr_pkg::t_cmd               cmd;
    bgr_pkg::t_sts               sts;
    logic signed [DATA_WIDTH-1:0] g [bgr_pkg::NUM_ENT];
    logic signed [DATA_WIDTH-1:0] r [bgr_pkg::NUM_ENT];

    assign g = '{i_g11, i_g12, i_g13, i_g21, i_g22, i_g23, i_g31, i_g32, i_g33};
    assign o_cfg_ready = 1'b1;

    bgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .o_stall    (o_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bgr_dpath #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_g     (g),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_r     (r),
        .o_status(o_status)
    );

    assign o_r11 = r[0];
    assign o_r12 = r[1];
    assign o_r13 = r[2];
    assign o_r21 = r[3];
    assign o_r22 = r[4];
    assign o_r23 = r[5];
    assign o_r31 = r[6];
    assign o_r32 = r[7];
    assign o_r33 = r[8];

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int W = 32;
    localparam int WATCHDOG = 6000;
    localparam logic signed [127:0] HALF = 128'sd8388608;

    typedef struct {
        logic op;
        logic signed [W-1:0] g [9];
    } t_grad_req;

    typedef struct {
        logic signed [W-1:0] r [9];
        logic st;
    } t_rel_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_op = 1'b0;
    logic signed [W-1:0] g_drv [9];
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [W-1:0] o_r [9];
    logic o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    t_grad_req pending_grads [$];
    t_rel_res expected_rel [$];
    logic captured_m;
    logic signed [W-1:0] inverse_m [9];
    logic pass_m;
    logic in_acc = 1'b0;
    logic quiet_mode = 1'b0;
    int src_gap = 0;
    int snk_gap = 0;
    int idle_cycles = 0;
    int errors = 0;

    initial for (int k = 0; k < 9; k++) g_drv[k] = '0;

    always #5 i_clk = ~i_clk;

    birth_gradient_rereference_3x3 #(.DATA_WIDTH(W)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_op(i_op),
        .i_g11(g_drv[0]), .i_g12(g_drv[1]), .i_g13(g_drv[2]),
        .i_g21(g_drv[3]), .i_g22(g_drv[4]), .i_g23(g_drv[5]),
        .i_g31(g_drv[6]), .i_g32(g_drv[7]), .i_g33(g_drv[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_r11(o_r[0]), .o_r12(o_r[1]), .o_r13(o_r[2]),
        .o_r21(o_r[3]), .o_r22(o_r[4]), .o_r23(o_r[5]),
        .o_r31(o_r[6]), .o_r32(o_r[7]), .o_r33(o_r[8]),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    function automatic logic signed [W-1:0] sat_q(logic signed [127:0] x);
        if (x > 128'sd2147483647) return 32'sh7fffffff;
        if (x < -128'sd2147483648) return 32'sh80000000;
        return x[W-1:0];
    endfunction

    function automatic logic signed [127:0] round_q(logic signed [127:0] x);
        return (x + HALF) >>> 24;
    endfunction

    function automatic logic signed [W-1:0] divide_q(logic signed [127:0] c,
                                                     logic signed [127:0] d);
        logic neg;
        logic [127:0] ac, ad, q;
        logic signed [127:0] v;
        neg = (c < 0) != (d < 0);
        ac = (c < 0) ? -c : c;
        ad = (d < 0) ? -d : d;
        q = ((ac << 24) + ad / 2) / ad;
        v = q;
        return sat_q(neg ? -v : v);
    endfunction

    function automatic logic capture_birth(logic signed [W-1:0] m [9]);
        int ia [9] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
        int ib [9] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
        int ic [9] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
        int id [9] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
        int tr [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
        logic signed [W-1:0] c [9];
        logic signed [127:0] mn, a, b, e, f, det;
        for (int k = 0; k < 9; k++) begin
            a = m[ia[k]]; b = m[ib[k]]; e = m[ic[k]]; f = m[id[k]];
            mn = a * b - e * f;
            if (k % 2 == 1) mn = -mn;
            c[k] = sat_q(round_q(mn));
        end
        det = 0;
        for (int k = 0; k < 3; k++) begin
            a = m[k]; b = c[k];
            det += round_q(a * b);
        end
        if (det == 0) return 1'b0;
        for (int k = 0; k < 9; k++) inverse_m[k] = divide_q(c[tr[k]], det);
        return 1'b1;
    endfunction

    task automatic reset_birth();
        for (int k = 0; k < 9; k++) inverse_m[k] = (k % 4 == 0) ? 32'sh01000000 : '0;
        captured_m = 1'b0;
    endtask

    task automatic predict_relative(t_grad_req q);
        t_rel_res res;
        logic signed [127:0] s, a, b;
        if (q.op) begin
            reset_birth();
            return;
        end
        res.st = 1'b0;
        if (pass_m) begin
            res.r = q.g;
        end else if (!captured_m && !capture_birth(q.g)) begin
            for (int k = 0; k < 9; k++) res.r[k] = '0;
            res.st = 1'b1;
        end else begin
            captured_m = 1'b1;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    s = 0;
                    for (int k = 0; k < 3; k++) begin
                        a = q.g[3*i+k]; b = inverse_m[3*k+j];
                        s += a * b;
                    end
                    res.r[3*i+j] = sat_q(round_q(s));
                end
            end
        end
        expected_rel.push_back(res);
    endtask

    initial reset_birth();
    initial pass_m = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_acc) begin
            i_valid <= 1'b1;
        end else if (src_gap > 0) begin
            src_gap--;
            i_valid <= 1'b0;
        end else if (pending_grads.size() > 0) begin
            t_grad_req q;
            q = pending_grads.pop_front();
            i_op <= q.op;
            for (int k = 0; k < 9; k++) g_drv[k] <= q.g[k];
            i_valid <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 8);
        end else begin
            i_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (!quiet_mode && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 8);
        end
    end

    always @(posedge i_clk) begin
        t_grad_req q;
        t_rel_res e;
        logic acc_in, acc_out, acc_cfg;
        acc_in = i_rst_n && i_valid && !o_stall;
        acc_out = i_rst_n && o_valid && !i_stall;
        acc_cfg = i_rst_n && i_cfg_valid && o_cfg_ready;
        in_acc <= acc_in;
        if (acc_cfg) pass_m = i_cfg_data;
        if (acc_in) begin
            q.op = i_op;
            q.g = g_drv;
            predict_relative(q);
        end
        if (acc_out) begin
            if (expected_rel.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = expected_rel.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (o_r[k] !== e.r[k]) begin
                        $error("r%0d%0d expected %h actual %h", k / 3 + 1, k % 3 + 1,
                               e.r[k], o_r[k]);
                        errors++;
                    end
                end
                if (o_status !== e.st) begin
                    $error("status expected %b actual %b", e.st, o_status);
                    errors++;
                end
            end
        end
        if (acc_in || acc_out || acc_cfg || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("[birth_gradient_rereference_3x3] ERROR");
            $finish;
        end
    end

    function automatic t_grad_req make_grad(int kind);
        t_grad_req q;
        q.op = 1'b0;
        for (int k = 0; k < 9; k++) begin
            case (kind)
                0: q.g[k] = (k % 4 == 0 ? 32'sh01000000 : 0) + $signed($urandom_range(0, 1 << 23))
                            - 32'sh00400000;
                1: q.g[k] = $urandom;
                2: q.g[k] = $signed($urandom_range(0, 1 << 26)) - 32'sh02000000;
                default: q.g[k] = (k % 4 == 0) ? $signed($urandom_range(1, 1 << 21)) :
                                  $signed($urandom_range(0, 1 << 12)) - 32'sh800;
            endcase
        end
        if (kind == 1 && $urandom_range(0, 3) == 0)
            for (int k = 0; k < 3; k++) q.g[6+k] = q.g[k];
        return q;
    endfunction

    function automatic t_grad_req const_grad(logic op, logic signed [W-1:0] v,
                                             logic signed [W-1:0] dg);
        t_grad_req q;
        q.op = op;
        for (int k = 0; k < 9; k++) q.g[k] = (k % 4 == 0) ? dg : v;
        return q;
    endfunction

    task automatic write_mode(logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_grads.size() > 0 || i_valid || expected_rel.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 14) == 0) pending_grads.push_back(const_grad(1'b1, 0, 0));
            else pending_grads.push_back(make_grad($urandom_range(0, 3)));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        pending_grads.push_back(const_grad(1'b0, 0, 32'sh01000000));
        pending_grads.push_back(const_grad(1'b0, 32'sh7fffffff, 32'sh7fffffff));
        pending_grads.push_back(const_grad(1'b0, 32'sh80000000, 32'sh80000000));
        pending_grads.push_back(const_grad(1'b1, 0, 0));
        pending_grads.push_back(const_grad(1'b0, 0, 0));
        pending_grads.push_back(const_grad(1'b0, 0, 32'sd1));
        pending_grads.push_back(const_grad(1'b0, 32'sh7fffffff, 32'sh80000000));
        pending_grads.push_back(const_grad(1'b0, 32'sh00400000, 32'sh00100000));
        pending_grads.push_back(const_grad(1'b0, 32'sh7fffffff, 32'sh7fffffff));
        pending_grads.push_back(const_grad(1'b0, 32'sh80000000, 32'sh80000000));
        pending_grads.push_back(const_grad(1'b1, 0, 0));
        pending_grads.push_back(const_grad(1'b0, 32'sh80000000, 32'sh7fffffff));
        pending_grads.push_back(const_grad(1'b0, 32'sh01000000, 32'sh01000000));
        drain();

        write_mode(1'b1);
        pending_grads.push_back(const_grad(1'b0, 32'sh7fffffff, 32'sh80000000));
        pending_grads.push_back(const_grad(1'b0, 32'sh80000000, 32'sh7fffffff));
        pending_grads.push_back(const_grad(1'b1, 0, 0));
        pending_grads.push_back(make_grad(1));
        drain();

        write_mode(1'b0);
        random_phase(300);
        drain();
        write_mode(1'b1);
        random_phase(100);
        drain();
        write_mode(1'b0);
        random_phase(100);
        drain();
        quiet_mode = 1'b1;
        random_phase(250);
        drain();

        if (errors == 0) begin
            $display("[birth_gradient_rereference_3x3] OK");
        end else begin
            $display("[birth_gradient_rereference_3x3] ERROR");
        end
        $finish;
    end
endmodule

### sim.f
rtl/bgr_pkg.sv
rtl/bgr_div.sv
rtl/bgr_dpath.sv
rtl/bgr_ctrl.sv
rtl/birth_gradient_rereference_3x3.sv
tb/tb.sv
